// ----- rtl/alie_pkg.sv -----
package alie_pkg;

   // Operation codes carried by req_func
   localparam logic [2:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [2:0] FN_PUSH_BACK  = 3'd1;
   localparam logic [2:0] FN_INSERT_AT  = 3'd2;
   localparam logic [2:0] FN_POP_FRONT  = 3'd3;
   localparam logic [2:0] FN_POP_BACK   = 3'd4;
   localparam logic [2:0] FN_ERASE_AT   = 3'd5;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_PLACE,
      ST_SHRINK,
      ST_RD_FRONT,
      ST_RD_BACK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take;
      logic setup;
      logic rd_move;
      logic wr_move;
      logic place;
      logic shrink;
      logic rd_front;
      logic rd_back;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic grow;
      logic modify;
      logic move_pending;
      logic rsp_free;
   } stat_type;

endpackage

// ----- rtl/alie_ctrl.sv -----
module alie_ctrl
   import alie_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.modify ? ST_STEP : ST_RD_FRONT;
         end
         ST_STEP: begin
            if (stat.move_pending) begin
               state_in = ST_MOVE_RD;
            end else begin
               state_in = stat.grow ? ST_PLACE : ST_SHRINK;
            end
         end
         ST_MOVE_RD:  state_in = ST_MOVE_WR;
         ST_MOVE_WR:  state_in = ST_STEP;
         ST_PLACE:    state_in = ST_RD_FRONT;
         ST_SHRINK:   state_in = ST_RD_FRONT;
         ST_RD_FRONT: state_in = ST_RD_BACK;
         ST_RD_BACK:  state_in = ST_DONE;
         ST_DONE: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_CHECK:    cmd.setup    = 1'b1;
         ST_STEP:     ;
         ST_MOVE_RD:  cmd.rd_move  = 1'b1;
         ST_MOVE_WR:  cmd.wr_move  = 1'b1;
         ST_PLACE:    cmd.place    = 1'b1;
         ST_SHRINK:   cmd.shrink   = 1'b1;
         ST_RD_FRONT: cmd.rd_front = 1'b1;
         ST_RD_BACK:  cmd.rd_back  = 1'b1;
         ST_DONE:     cmd.finish   = stat.rsp_free;
         default:     ;
      endcase
   end

endmodule

// ----- rtl/alie_dp.sv -----
module alie_dp
   import alie_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_func,
   input  logic signed [15:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic signed [15:0] rsp_front_value,
   output logic signed [15:0] rsp_back_value,
   input  cmd_type            cmd,
   output stat_type           stat
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
   localparam int RO_W   = (VALUE_BITS > 16) ? VALUE_BITS : 16;

   logic [VALUE_BITS-1:0] mem [CAPACITY];

   logic [2:0]            func_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [4:0]            pos_ff;
   logic [CNT_W-1:0]      fill_ff;
   logic [CNT_W-1:0]      fill_in;
   logic [CNT_W-1:0]      cursor_ff;
   logic [CNT_W-1:0]      target_ff;
   logic                  grow_ff;
   status_type            status_ff;
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [VALUE_BITS-1:0] front_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [4:0]            rsp_count_ff;
   logic [15:0]           rsp_front_ff;
   logic [15:0]           rsp_back_ff;

   logic signed [RO_W-1:0] value_wide;
   logic [CMP_W-1:0]       pos_wide;
   logic [CMP_W-1:0]       fill_wide;
   logic                   is_grow;
   logic                   is_shrink;
   status_type             status_now;
   logic [CNT_W-1:0]       target_now;
   logic [CNT_W-1:0]       fill_less;
   logic [RO_W-1:0]        front_wide;
   logic [RO_W-1:0]        back_wide;
   logic [CNT_W:0]         cursor_next_up;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [VALUE_BITS-1:0]  wr_data;

   assign value_wide = RO_W'(req_value);
   assign pos_wide   = CMP_W'(pos_ff);
   assign fill_wide  = CMP_W'(fill_ff);
   assign fill_less  = fill_ff - CNT_W'(1);

   // Classify the latched request against the current fill
   always_comb begin
      is_grow    = (func_ff == FN_PUSH_FRONT) || (func_ff == FN_PUSH_BACK) ||
                   (func_ff == FN_INSERT_AT);
      is_shrink  = (func_ff == FN_POP_FRONT) || (func_ff == FN_POP_BACK) ||
                   (func_ff == FN_ERASE_AT);
      status_now = STAT_OK;
      if (is_grow) begin
         if (fill_ff >= CNT_W'(CAPACITY)) begin
            status_now = STAT_FULL;
         end else if ((func_ff == FN_INSERT_AT) && (pos_wide > fill_wide)) begin
            status_now = STAT_RANGE;
         end
      end else if (is_shrink) begin
         if (fill_ff == '0) begin
            status_now = STAT_EMPTY;
         end else if ((func_ff == FN_ERASE_AT) && (pos_wide >= fill_wide)) begin
            status_now = STAT_RANGE;
         end
      end
   end

   always_comb begin
      target_now = '0;
      if (func_ff == FN_PUSH_BACK) begin
         target_now = fill_ff;
      end else if (func_ff == FN_POP_BACK) begin
         target_now = fill_less;
      end else if ((func_ff == FN_INSERT_AT) || (func_ff == FN_ERASE_AT)) begin
         target_now = pos_wide[CNT_W-1:0];
      end
   end

   assign cursor_next_up = {1'b0, cursor_ff} + (CNT_W+1)'(1);

   assign stat.grow         = grow_ff;
   assign stat.modify       = (is_grow || is_shrink) && (status_now == STAT_OK);
   assign stat.move_pending = grow_ff ? (cursor_ff > target_ff)
                                      : (cursor_next_up < {1'b0, fill_ff});
   assign stat.rsp_free     = !rsp_valid_ff || rsp_ready;

   // Request latch and move bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff  <= req_func;
         value_ff <= value_wide[VALUE_BITS-1:0];
         pos_ff   <= req_position;
      end
      if (cmd.setup) begin
         status_ff <= status_now;
         grow_ff   <= is_grow;
         target_ff <= target_now;
         cursor_ff <= is_grow ? fill_ff : target_now;
      end else if (cmd.wr_move) begin
         cursor_ff <= grow_ff ? (cursor_ff - CNT_W'(1)) : cursor_next_up[CNT_W-1:0];
      end
      if (cmd.rd_back) begin
         front_ff <= rd_data_ff;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (cmd.place) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (cmd.shrink) begin
         fill_in = fill_less;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Entry store: one write and one registered read each cycle
   always_comb begin
      priority if (cmd.rd_front) begin
         rd_addr = '0;
      end else if (cmd.rd_move) begin
         rd_addr = grow_ff ? ADDR_W'(cursor_ff - CNT_W'(1))
                           : ADDR_W'(cursor_next_up);
      end else begin
         rd_addr = fill_less[ADDR_W-1:0];
      end
   end

   assign wr_en   = cmd.wr_move || cmd.place;
   assign wr_addr = cmd.place ? target_ff[ADDR_W-1:0] : cursor_ff[ADDR_W-1:0];
   assign wr_data = cmd.place ? value_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Result register
   assign front_wide = RO_W'(front_ff);
   assign back_wide  = RO_W'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= fill_wide[4:0];
         rsp_front_ff  <= (fill_ff == '0) ? 16'd0 : front_wide[15:0];
         rsp_back_ff   <= (fill_ff == '0) ? 16'd0 : back_wide[15:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_front_value = $signed(rsp_front_ff);
   assign rsp_back_value  = $signed(rsp_back_ff);

endmodule

// ----- rtl/array_list_insert_erase.sv -----
// A rejected or unused request is checked, then the front and back entries are read for the
// result; one that changes the list first shifts the entries beyond the position one at a
// time (up to CAPACITY-1 of them), each move a read then a write of the entry store, which
// has one read and one write port. Items are taken one at a time; the next is taken once
// the result is registered. A waiting result does not block acceptance.
// Reset (synchronous, active high) empties the list; entry contents are not cleared.
module array_list_insert_erase
   import alie_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_func,
   input  logic signed [15:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_count,
   output logic signed [15:0] rsp_front_value,
   output logic signed [15:0] rsp_back_value
);

   // Command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // Sequencer: check the request, walk the shift one entry at a time,
   // then read back the front and back entries for the result
   alie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: request latch, fill count, entry store and result register
   alie_dp #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_count       (rsp_count),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule
